// ===== rtl/core/dvg_pkg.sv =====
// ---------------------------------------------------------------------------
// dvg_pkg: shared types and constants of the disk vertex generator
// widths, register codes, reset values, polynomial coefficients, latencies
// ---------------------------------------------------------------------------
package dvg_pkg;

    // register limits
    localparam int MAX_SLICES = 1024;
    localparam int MAX_RINGS  = 1024;

    // configuration register indexes
    localparam logic [1:0] CFG_INNER  = 2'd0;
    localparam logic [1:0] CFG_OUTER  = 2'd1;
    localparam logic [1:0] CFG_SLICES = 2'd2;
    localparam logic [1:0] CFG_RINGS  = 2'd3;

    // reset values
    localparam logic [30:0] INNER_RST  = 31'd0;
    localparam logic [30:0] OUTER_RST  = 31'd65536;
    localparam logic [10:0] SLICES_RST = 11'd16;
    localparam logic [10:0] RINGS_RST  = 11'd1;
    localparam logic signed [31:0] DR_RST =
        32'((int'(OUTER_RST) - int'(INNER_RST)) / int'(RINGS_RST));

    // odd taylor coefficients of sin(pi/2*x), q1.30
    localparam logic [31:0] KC1 = 32'd1686629713;
    localparam logic [31:0] KC3 = 32'd693598668;
    localparam logic [31:0] KC5 = 32'd85569306;
    localparam logic [31:0] KC7 = 32'd5026995;
    localparam logic [31:0] KC9 = 32'd172270;

    // fixed point constants
    localparam logic [30:0] ONE_Q30  = 31'd1073741824;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    // stage counts of the pipeline sections
    localparam int PH_LAT = 16;
    localparam int QS_LAT = 7;
    localparam int TD_LAT = 18;

    // configuration seen by the datapath
    typedef struct packed {
        logic [30:0]        inner;
        logic [30:0]        outer;
        logic [10:0]        slices;
        logic [10:0]        rings;
        logic signed [31:0] dr;
        logic               bad;
    } t_cfg;

endpackage

// ===== rtl/core/disk_vertex_generator.sv =====
// ---------------------------------------------------------------------------
// disk_vertex_generator: quad strip vertex pairs of a flat disk
// a start transfer passes the phase divider, quarter sines, product and texture dividers to o_valid
// throughput: one request per cycle while busy is low, set by the fully pipelined datapath
// a configuration write holds busy high while dr is divided
// reset: synchronous active low, control and configuration registers return to their defaults
// results cannot be held off by the receiver
// ---------------------------------------------------------------------------
module disk_vertex_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         i_ring,
    input  logic [10:0]        i_slice,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_outer_x,
    output logic signed [31:0] o_outer_y,
    output logic [16:0]        o_outer_s,
    output logic [16:0]        o_outer_t,
    output logic signed [31:0] o_inner_x,
    output logic signed [31:0] o_inner_y,
    output logic [16:0]        o_inner_s,
    output logic [16:0]        o_inner_t,
    output logic               o_strip_end,
    output logic               o_bad_index
);

    localparam int L_SIN = dvg_pkg::PH_LAT + dvg_pkg::QS_LAT;
    localparam int L_MUL = L_SIN + 1;
    localparam int L_POS = L_MUL + 1;
    localparam int L_TEX = L_MUL + dvg_pkg::TD_LAT;
    localparam int L_OUT = L_TEX + 1;

    localparam logic [1:0] QD_FIRST  = 2'd0;
    localparam logic [1:0] QD_SECOND = 2'd1;
    localparam logic [1:0] QD_THIRD  = 2'd2;
    localparam logic [1:0] QD_FOURTH = 2'd3;

    typedef struct packed {
        logic valid;
        logic bad;
        logic send;
    } t_ctl;

    typedef struct packed {
        logic [30:0] rin;
        logic [30:0] rout;
    } t_rad;

    typedef struct packed {
        logic [47:0] os;
        logic [47:0] oc;
        logic [47:0] is;
        logic [47:0] ic;
        logic        ns;
        logic        nc;
    } t_prd;

    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] ix;
        logic [31:0] iy;
    } t_pos;

    dvg_pkg::t_cfg cfg;
    logic          cfg_busy;
    logic          accept;
    logic [31:0]   phase;
    logic [30:0]   xa;
    logic [30:0]   xb;
    logic [16:0]   sin_a;
    logic [16:0]   sin_b;
    logic [16:0]   ms;
    logic [16:0]   mc;
    logic          ns;
    logic          nc;
    logic [16:0]   tex_os;
    logic [16:0]   tex_oc;
    logic [16:0]   tex_is;
    logic [16:0]   tex_ic;
    logic signed [42:0] r1_full;
    logic signed [42:0] r2_full;

    t_ctl          r_ctl [1:L_TEX];
    t_rad          r_rad [1:L_SIN];
    logic [1:0]    r_qd  [dvg_pkg::PH_LAT+1:L_SIN];
    t_prd          r_prd;
    t_pos          r_pos [L_POS:L_TEX];

    logic               r_o_valid;
    logic signed [31:0] r_o_ox;
    logic signed [31:0] r_o_oy;
    logic [16:0]        r_o_os;
    logic [16:0]        r_o_ot;
    logic signed [31:0] r_o_ix;
    logic signed [31:0] r_o_iy;
    logic [16:0]        r_o_is;
    logic [16:0]        r_o_it;
    logic               r_o_send;
    logic               r_o_bad;

    // rounded, saturated and signed position
    function automatic logic [31:0] pos_fix(input logic [47:0] p, input logic neg);
        logic [47:0] v;
        logic [31:0] m;
        v = (p + 48'd32768) >> 16;
        m = (v > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
        return neg ? 32'(-m) : m;
    endfunction

    // configuration and dr divider
    dvg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg),
        .o_busy  (cfg_busy)
    );

    assign busy   = cfg_busy | i_cfg_we;
    assign accept = start & ~busy;

    // ring radii
    assign r1_full = $signed({12'd0, cfg.inner}) + $signed({1'b0, i_ring}) * cfg.dr;
    assign r2_full = r1_full + 43'(cfg.dr);

    // phase of the slice angle
    dvg_phase u_phase (
        .i_clk    (i_clk),
        .i_slice  (i_slice),
        .i_slices (cfg.slices),
        .o_phase  (phase)
    );

    // quadrant reduction
    assign xa = {1'b0, phase[29:0]};
    assign xb = dvg_pkg::ONE_Q30 - {1'b0, phase[29:0]};

    dvg_qsin u_sin_a (
        .i_clk (i_clk),
        .i_x   (xa),
        .o_sin (sin_a)
    );

    dvg_qsin u_sin_b (
        .i_clk (i_clk),
        .i_x   (xb),
        .o_sin (sin_b)
    );

    // sine and cosine from quadrant
    always_comb begin
        case (r_qd[L_SIN])
            QD_FIRST:  begin ms = sin_a; ns = 1'b0; mc = sin_b; nc = 1'b0; end
            QD_SECOND: begin ms = sin_b; ns = 1'b0; mc = sin_a; nc = 1'b1; end
            QD_THIRD:  begin ms = sin_a; ns = 1'b1; mc = sin_b; nc = 1'b1; end
            QD_FOURTH: begin ms = sin_b; ns = 1'b1; mc = sin_a; nc = 1'b0; end
            default:   begin ms = sin_a; ns = 1'b0; mc = sin_b; nc = 1'b0; end
        endcase
    end

    // texture dividers
    dvg_tex_div u_tex_os (
        .i_clk   (i_clk),
        .i_num   (r_prd.os + 48'(cfg.outer)),
        .i_neg   (r_prd.ns),
        .i_outer (cfg.outer),
        .o_coord (tex_os)
    );

    dvg_tex_div u_tex_oc (
        .i_clk   (i_clk),
        .i_num   (r_prd.oc + 48'(cfg.outer)),
        .i_neg   (r_prd.nc),
        .i_outer (cfg.outer),
        .o_coord (tex_oc)
    );

    dvg_tex_div u_tex_is (
        .i_clk   (i_clk),
        .i_num   (r_prd.is + 48'(cfg.outer)),
        .i_neg   (r_prd.ns),
        .i_outer (cfg.outer),
        .o_coord (tex_is)
    );

    dvg_tex_div u_tex_ic (
        .i_clk   (i_clk),
        .i_num   (r_prd.ic + 48'(cfg.outer)),
        .i_neg   (r_prd.nc),
        .i_outer (cfg.outer),
        .o_coord (tex_ic)
    );

    // control line, carries valid through every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= L_TEX; k++) begin
                r_ctl[k] <= '0;
            end
            r_o_valid <= 1'b0;
        end else begin
            r_ctl[1].valid <= accept;
            r_ctl[1].bad   <= cfg.bad || ({1'b0, i_ring} >= cfg.rings) ||
                              (i_slice > cfg.slices);
            r_ctl[1].send  <= (i_slice == cfg.slices);
            for (int k = 2; k <= L_TEX; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_o_valid <= r_ctl[L_TEX].valid;
        end
    end

    // payload lines and arithmetic stages
    always_ff @(posedge i_clk) begin
        r_rad[1].rin  <= r1_full[30:0];
        r_rad[1].rout <= r2_full[30:0];
        for (int k = 2; k <= L_SIN; k++) begin
            r_rad[k] <= r_rad[k-1];
        end
        r_qd[dvg_pkg::PH_LAT+1] <= phase[31:30];
        for (int k = dvg_pkg::PH_LAT + 2; k <= L_SIN; k++) begin
            r_qd[k] <= r_qd[k-1];
        end
        // radius times sine and cosine magnitude
        r_prd.os <= 48'(r_rad[L_SIN].rout) * 48'(ms);
        r_prd.oc <= 48'(r_rad[L_SIN].rout) * 48'(mc);
        r_prd.is <= 48'(r_rad[L_SIN].rin) * 48'(ms);
        r_prd.ic <= 48'(r_rad[L_SIN].rin) * 48'(mc);
        r_prd.ns <= ns;
        r_prd.nc <= nc;
        // positions
        r_pos[L_POS].ox <= pos_fix(r_prd.os, r_prd.ns);
        r_pos[L_POS].oy <= pos_fix(r_prd.oc, r_prd.nc);
        r_pos[L_POS].ix <= pos_fix(r_prd.is, r_prd.ns);
        r_pos[L_POS].iy <= pos_fix(r_prd.ic, r_prd.nc);
        for (int k = L_POS + 1; k <= L_TEX; k++) begin
            r_pos[k] <= r_pos[k-1];
        end
        // result register, zeroed for a bad request
        if (r_ctl[L_TEX].bad) begin
            r_o_ox   <= '0;
            r_o_oy   <= '0;
            r_o_os   <= '0;
            r_o_ot   <= '0;
            r_o_ix   <= '0;
            r_o_iy   <= '0;
            r_o_is   <= '0;
            r_o_it   <= '0;
            r_o_send <= 1'b0;
        end else begin
            r_o_ox   <= $signed(r_pos[L_TEX].ox);
            r_o_oy   <= $signed(r_pos[L_TEX].oy);
            r_o_os   <= tex_os;
            r_o_ot   <= tex_oc;
            r_o_ix   <= $signed(r_pos[L_TEX].ix);
            r_o_iy   <= $signed(r_pos[L_TEX].iy);
            r_o_is   <= tex_is;
            r_o_it   <= tex_ic;
            r_o_send <= r_ctl[L_TEX].send;
        end
        r_o_bad <= r_ctl[L_TEX].bad;
    end

    assign o_valid     = r_o_valid;
    assign o_outer_x   = r_o_ox;
    assign o_outer_y   = r_o_oy;
    assign o_outer_s   = r_o_os;
    assign o_outer_t   = r_o_ot;
    assign o_inner_x   = r_o_ix;
    assign o_inner_y   = r_o_iy;
    assign o_inner_s   = r_o_is;
    assign o_inner_t   = r_o_it;
    assign o_strip_end = r_o_send;
    assign o_bad_index = r_o_bad;

    // every accepted request comes out after the full pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(L_OUT) o_valid)
        else $error("result strobe missing after request transfer");

    // a register write blocks new requests while dr is recomputed
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("busy low after configuration write");

    // texture coordinates stay within the unit range
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_outer_s <= dvg_pkg::ONE_Q16) && (o_outer_t <= dvg_pkg::ONE_Q16) &&
                    (o_inner_s <= dvg_pkg::ONE_Q16) && (o_inner_t <= dvg_pkg::ONE_Q16))
        else $error("texture coordinate out of range");

    // a rejected request carries no geometry
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_index) |-> (o_outer_x == 0) && (o_inner_y == 0) &&
                                     (o_outer_s == 0) && !o_strip_end)
        else $error("bad request with non-zero result");

endmodule

// ===== rtl/core/dvg_cfg.sv =====
// ---------------------------------------------------------------------------
// dvg_cfg: configuration registers and ring step divider
// holds the registers and works out dr = (outer - inner) / rings after a write
// ---------------------------------------------------------------------------
module dvg_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [1:0]          i_idx,
    input  logic [30:0]         i_data,
    output dvg_pkg::t_cfg       o_cfg,
    output logic                o_busy
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_SIGN} t_state;

    t_state             r_state;
    logic [30:0]        r_inner;
    logic [30:0]        r_outer;
    logic [10:0]        r_slices;
    logic [10:0]        r_rings;
    logic signed [31:0] r_dr;
    logic [4:0]         r_cnt;
    logic [31:0]        r_num;
    logic [10:0]        r_rem;
    logic               r_neg;

    logic signed [31:0] diff;
    logic [31:0]        mag;
    logic [11:0]        trial;
    logic               ge;
    logic [11:0]        n_rem_w;
    logic [10:0]        n_rem;
    logic [31:0]        n_num;

    // magnitude of the radius span
    assign diff = $signed({1'b0, r_outer}) - $signed({1'b0, r_inner});
    assign mag  = diff[31] ? 32'(-diff) : 32'(diff);

    // one restoring division step
    always_comb begin
        trial   = {r_rem, r_num[31]};
        ge      = (trial >= {1'b0, r_rings});
        n_rem_w = ge ? (trial - {1'b0, r_rings}) : trial;
        n_rem   = n_rem_w[10:0];
        n_num   = {r_num[30:0], ge};
    end

    // register writes and divider sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_inner  <= dvg_pkg::INNER_RST;
            r_outer  <= dvg_pkg::OUTER_RST;
            r_slices <= dvg_pkg::SLICES_RST;
            r_rings  <= dvg_pkg::RINGS_RST;
            r_dr     <= dvg_pkg::DR_RST;
            r_cnt    <= '0;
            r_num    <= '0;
            r_rem    <= '0;
            r_neg    <= 1'b0;
        end else if (i_we) begin
            case (i_idx)
                dvg_pkg::CFG_INNER:  r_inner  <= i_data;
                dvg_pkg::CFG_OUTER:  r_outer  <= i_data;
                dvg_pkg::CFG_SLICES: r_slices <= i_data[10:0];
                dvg_pkg::CFG_RINGS:  r_rings  <= i_data[10:0];
                default: ;
            endcase
            r_state <= ST_LOAD;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    r_num   <= mag;
                    r_neg   <= diff[31];
                    r_rem   <= '0;
                    r_cnt   <= 5'd31;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                    if (r_cnt == 5'd0) begin
                        r_state <= ST_SIGN;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                ST_SIGN: begin
                    r_dr    <= r_neg ? -$signed(r_num) : $signed(r_num);
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // outputs
    assign o_busy       = (r_state != ST_IDLE);
    assign o_cfg.inner  = r_inner;
    assign o_cfg.outer  = r_outer;
    assign o_cfg.slices = r_slices;
    assign o_cfg.rings  = r_rings;
    assign o_cfg.dr     = r_dr;
    assign o_cfg.bad    = (r_slices == 11'd0) || (r_slices > 11'(dvg_pkg::MAX_SLICES)) ||
                          (r_rings == 11'd0) || (r_rings > 11'(dvg_pkg::MAX_RINGS));

endmodule

// ===== rtl/core/dvg_phase.sv =====
// ---------------------------------------------------------------------------
// dvg_phase: angle phase divider
// pipelined long division floor(slice * 2^32 / slices), two bits per stage
// ---------------------------------------------------------------------------
module dvg_phase (
    input  logic        i_clk,
    input  logic [10:0] i_slice,
    input  logic [10:0] i_slices,
    output logic [31:0] o_phase
);

    logic [10:0] r_rem [1:dvg_pkg::PH_LAT];
    logic [31:0] r_q   [1:dvg_pkg::PH_LAT];

    logic [10:0] n_rem [1:dvg_pkg::PH_LAT];
    logic [31:0] n_q   [1:dvg_pkg::PH_LAT];
    logic [10:0] rem0;

    // one bit of long division
    function automatic logic [11:0] div_step(input logic [10:0] rem, input logic [10:0] den);
        logic [11:0] t;
        logic        b;
        t = {rem, 1'b0};
        b = (t >= {1'b0, den});
        if (b) begin
            t = t - {1'b0, den};
        end
        return {b, t[10:0]};
    endfunction

    // last slice wraps to angle zero
    assign rem0 = (i_slice == i_slices) ? 11'd0 : i_slice;

    // two steps per stage
    always_comb begin
        logic [11:0] s1;
        logic [11:0] s2;
        s1       = div_step(rem0, i_slices);
        s2       = div_step(s1[10:0], i_slices);
        n_rem[1] = s2[10:0];
        n_q[1]   = {30'd0, s1[11], s2[11]};
        for (int k = 2; k <= dvg_pkg::PH_LAT; k++) begin
            s1       = div_step(r_rem[k-1], i_slices);
            s2       = div_step(s1[10:0], i_slices);
            n_rem[k] = s2[10:0];
            n_q[k]   = {r_q[k-1][29:0], s1[11], s2[11]};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= dvg_pkg::PH_LAT; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
        end
    end

    assign o_phase = r_q[dvg_pkg::PH_LAT];

endmodule

// ===== rtl/core/dvg_qsin.sv =====
// ---------------------------------------------------------------------------
// dvg_qsin: quarter wave sine
// degree nine odd polynomial by horner's rule, at most one multiply per stage
// ---------------------------------------------------------------------------
module dvg_qsin (
    input  logic        i_clk,
    input  logic [30:0] i_x,
    output logic [16:0] o_sin
);

    logic [61:0] r_sq;
    logic [30:0] r_x  [1:5];
    logic [30:0] r_v  [2:5];
    logic [61:0] r_pr [2:6];
    logic [16:0] r_out;

    logic [32:0] rnd;

    // coefficient minus shifted product
    function automatic logic [30:0] hstep(input logic [31:0] k, input logic [61:0] pr);
        logic [31:0] d;
        d = k - pr[61:30];
        return d[30:0];
    endfunction

    assign rnd = {1'b0, r_pr[6][61:30]} + 33'd8192;

    // horner stages
    always_ff @(posedge i_clk) begin
        r_x[1]  <= i_x;
        r_sq    <= 62'(i_x) * 62'(i_x);
        r_x[2]  <= r_x[1];
        r_v[2]  <= r_sq[60:30];
        r_pr[2] <= 62'(dvg_pkg::KC9) * 62'(r_sq[60:30]);
        for (int k = 3; k <= 5; k++) begin
            r_x[k] <= r_x[k-1];
            r_v[k] <= r_v[k-1];
        end
        r_pr[3] <= 62'(hstep(dvg_pkg::KC7, r_pr[2])) * 62'(r_v[2]);
        r_pr[4] <= 62'(hstep(dvg_pkg::KC5, r_pr[3])) * 62'(r_v[3]);
        r_pr[5] <= 62'(hstep(dvg_pkg::KC3, r_pr[4])) * 62'(r_v[4]);
        r_pr[6] <= 62'(hstep(dvg_pkg::KC1, r_pr[5])) * 62'(r_x[5]);
        // round to q16 and cap at one
        r_out   <= (rnd[32:14] > 19'(dvg_pkg::ONE_Q16)) ? dvg_pkg::ONE_Q16 : rnd[30:14];
    end

    assign o_sin = r_out;

endmodule

// ===== rtl/core/dvg_tex_div.sv =====
// ---------------------------------------------------------------------------
// dvg_tex_div: texture coordinate divider
// pipelined restoring division by twice the outer radius, then centre and clamp
// ---------------------------------------------------------------------------
module dvg_tex_div (
    input  logic        i_clk,
    input  logic [47:0] i_num,
    input  logic        i_neg,
    input  logic [30:0] i_outer,
    output logic [16:0] o_coord
);

    localparam int NB = 16;

    logic [47:0] r_rem [0:NB];
    logic        r_sat [0:NB];
    logic        r_neg [0:NB];
    logic [15:0] r_q   [1:NB];
    logic [16:0] r_out;

    logic [47:0] den;
    logic [47:0] n_rem [1:NB];
    logic [15:0] n_q   [1:NB];
    logic [16:0] qc;
    logic [16:0] val;

    assign den = {16'd0, i_outer, 1'b0};

    // one quotient bit per stage, most significant first
    always_comb begin
        logic [47:0] dsh;
        logic        b;
        for (int k = 1; k <= NB; k++) begin
            dsh = den << (NB - k);
            b   = (r_rem[k-1] >= dsh);
            n_rem[k] = b ? (r_rem[k-1] - dsh) : r_rem[k-1];
            if (k == 1) begin
                n_q[k] = {15'd0, b};
            end else begin
                n_q[k] = {r_q[k-1][14:0], b};
            end
        end
    end

    // quotient beyond one half saturates either way
    always_comb begin
        if (r_sat[NB] || ({1'b0, r_q[NB]} > dvg_pkg::HALF_Q16)) begin
            qc = dvg_pkg::HALF_Q16;
        end else begin
            qc = {1'b0, r_q[NB]};
        end
        if (i_outer == 31'd0) begin
            val = dvg_pkg::HALF_Q16;
        end else if (r_neg[NB]) begin
            val = dvg_pkg::HALF_Q16 - qc;
        end else begin
            val = dvg_pkg::HALF_Q16 + qc;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_sat[0] <= (i_num >= (den << NB));
        r_neg[0] <= i_neg;
        for (int k = 1; k <= NB; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
            r_sat[k] <= r_sat[k-1];
            r_neg[k] <= r_neg[k-1];
        end
        r_out <= val;
    end

    assign o_coord = r_out;

endmodule

// ===== tb/disk_vertex_generator_test.sv =====
// ---------------------------------------------------------------------------
// disk_vertex_generator_test: self-checking bench of the disk vertex generator
// a queue-fed driver issues ring/slice requests, mostly under random gaps, a bit-exact
// predictor works out each vertex pair and a monitor checks every strobe
// ---------------------------------------------------------------------------
module disk_vertex_generator_test;

    typedef struct {
        logic [9:0]  ring;
        logic [10:0] slice;
    } t_request;

    typedef struct {
        logic [31:0] outer_x;
        logic [31:0] outer_y;
        logic [16:0] outer_s;
        logic [16:0] outer_t;
        logic [31:0] inner_x;
        logic [31:0] inner_y;
        logic [16:0] inner_s;
        logic [16:0] inner_t;
        logic        strip_end;
        logic        bad_index;
    } t_vertex_pair;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    logic [9:0]         i_ring     = '0;
    logic [10:0]        i_slice    = '0;
    logic               i_cfg_we   = 1'b0;
    logic [1:0]         i_cfg_idx  = dvg_pkg::CFG_INNER;
    logic [30:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [31:0] o_outer_x;
    logic signed [31:0] o_outer_y;
    logic [16:0]        o_outer_s;
    logic [16:0]        o_outer_t;
    logic signed [31:0] o_inner_x;
    logic signed [31:0] o_inner_y;
    logic [16:0]        o_inner_s;
    logic [16:0]        o_inner_t;
    logic               o_strip_end;
    logic               o_bad_index;

    // bench copy of the configuration registers
    logic [30:0] cur_inner  = dvg_pkg::INNER_RST;
    logic [30:0] cur_outer  = dvg_pkg::OUTER_RST;
    logic [10:0] cur_slices = dvg_pkg::SLICES_RST;
    logic [10:0] cur_rings  = dvg_pkg::RINGS_RST;

    t_request     request_q[$];
    t_vertex_pair vertex_pair_q[$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           no_gaps = 1'b0;

    disk_vertex_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_ring(i_ring), .i_slice(i_slice),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_outer_x(o_outer_x), .o_outer_y(o_outer_y),
        .o_outer_s(o_outer_s), .o_outer_t(o_outer_t),
        .o_inner_x(o_inner_x), .o_inner_y(o_inner_y),
        .o_inner_s(o_inner_s), .o_inner_t(o_inner_t),
        .o_strip_end(o_strip_end), .o_bad_index(o_bad_index)
    );

    always #1 i_clk = ~i_clk;

    // sin(pi/2*x) for x in q1.30, result q16 capped at one
    function automatic longint quarter_sine(logic [63:0] x);
        logic [63:0] x2, p, y, r;
        x2 = (x * x) >> 30;
        p  = 64'(dvg_pkg::KC9);
        p  = 64'(dvg_pkg::KC7) - ((p * x2) >> 30);
        p  = 64'(dvg_pkg::KC5) - ((p * x2) >> 30);
        p  = 64'(dvg_pkg::KC3) - ((p * x2) >> 30);
        p  = 64'(dvg_pkg::KC1) - ((p * x2) >> 30);
        y  = (p * x) >> 30;
        r  = (y + 64'd8192) >> 14;
        if (r > 64'd65536) r = 64'd65536;
        return longint'(r);
    endfunction

    // radius times signed q16 sine, rounded and saturated
    function automatic logic [31:0] scale_position(longint r, longint s);
        longint      m, v;
        logic [63:0] prod;
        m    = (s < 0) ? -s : s;
        prod = (64'(r) * 64'(m) + 64'd32768) >> 16;
        v    = longint'(prod);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (s < 0) v = -v;
        return v[31:0];
    endfunction

    // texture coordinate centred on one half, saturated to the unit range
    function automatic logic [16:0] scale_texture(longint r, longint s);
        longint      m, q, v;
        logic [63:0] den;
        if (cur_outer == 0) return dvg_pkg::HALF_Q16;
        m   = (s < 0) ? -s : s;
        den = 64'(cur_outer) * 2;
        q   = longint'((64'(r) * 64'(m) + 64'(cur_outer)) / den);
        v   = 32768 + ((s < 0) ? -q : q);
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        return v[16:0];
    endfunction

    function automatic t_vertex_pair predict_vertex_pair(t_request req);
        t_vertex_pair vp;
        longint       dr, r1, r2, sn, cs, a, b;
        logic [63:0]  ph, frac;
        logic [1:0]   quad;
        vp = '{default: '0};
        if (cur_slices == 0 || cur_slices > dvg_pkg::MAX_SLICES || cur_rings == 0 ||
            cur_rings > dvg_pkg::MAX_RINGS || req.ring >= cur_rings ||
            req.slice > cur_slices) begin
            vp.bad_index = 1'b1;
            return vp;
        end
        dr = (longint'(cur_outer) - longint'(cur_inner)) / longint'(cur_rings);
        r1 = longint'(cur_inner) + longint'(req.ring) * dr;
        r2 = r1 + dr;
        ph = (req.slice == cur_slices) ? 64'd0 : (64'(req.slice) << 32) / 64'(cur_slices);
        quad = ph[31:30];
        frac = ph & 64'h3FFF_FFFF;
        a = quarter_sine(frac);
        b = quarter_sine(64'(dvg_pkg::ONE_Q30) - frac);
        case (quad)
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
        vp.outer_x   = scale_position(r2, sn);
        vp.outer_y   = scale_position(r2, cs);
        vp.outer_s   = scale_texture(r2, sn);
        vp.outer_t   = scale_texture(r2, cs);
        vp.inner_x   = scale_position(r1, sn);
        vp.inner_y   = scale_position(r1, cs);
        vp.inner_s   = scale_texture(r1, sn);
        vp.inner_t   = scale_texture(r1, cs);
        vp.strip_end = (req.slice == cur_slices);
        return vp;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // driver: holds a request until its transfer, then picks the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                vertex_pair_q.push_back(predict_vertex_pair(request_q.pop_front()));
            end
            if (!(start && busy)) begin
                if (request_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 35)) begin
                    start   <= 1'b1;
                    i_ring  <= request_q[0].ring;
                    i_slice <= request_q[0].slice;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe against the oldest prediction
    always @(posedge i_clk) begin
        t_vertex_pair exp_vp;
        if (i_rst_n && o_valid) begin
            if (vertex_pair_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual x %h", $time, o_outer_x);
            end else begin
                exp_vp = vertex_pair_q.pop_front();
                check_field("outer_x", exp_vp.outer_x, o_outer_x);
                check_field("outer_y", exp_vp.outer_y, o_outer_y);
                check_field("outer_s", 32'(exp_vp.outer_s), 32'(o_outer_s));
                check_field("outer_t", 32'(exp_vp.outer_t), 32'(o_outer_t));
                check_field("inner_x", exp_vp.inner_x, o_inner_x);
                check_field("inner_y", exp_vp.inner_y, o_inner_y);
                check_field("inner_s", 32'(exp_vp.inner_s), 32'(o_inner_s));
                check_field("inner_t", 32'(exp_vp.inner_t), 32'(o_inner_t));
                check_field("strip_end", 32'(exp_vp.strip_end), 32'(o_strip_end));
                check_field("bad_index", 32'(exp_vp.bad_index), 32'(o_bad_index));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("disk_vertex_generator_test: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            dvg_pkg::CFG_INNER:  cur_inner  = data;
            dvg_pkg::CFG_OUTER:  cur_outer  = data;
            dvg_pkg::CFG_SLICES: cur_slices = data[10:0];
            default:             cur_rings  = data[10:0];
        endcase
    endtask

    task automatic set_config(logic [30:0] inner, logic [30:0] outer,
                              logic [10:0] slices, logic [10:0] rings);
        write_reg(dvg_pkg::CFG_INNER, inner);
        write_reg(dvg_pkg::CFG_OUTER, outer);
        write_reg(dvg_pkg::CFG_SLICES, 31'(slices));
        write_reg(dvg_pkg::CFG_RINGS, 31'(rings));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_request(logic [9:0] ring, logic [10:0] slice);
        t_request req;
        req.ring  = ring;
        req.slice = slice;
        request_q.push_back(req);
    endtask

    // mostly valid indices, some noise over the full field range
    task automatic add_random_requests(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 80 && cur_rings != 0 && cur_slices != 0)
                add_request(10'($urandom_range(0, cur_rings > 1024 ? 1023 : cur_rings - 1)),
                            11'($urandom_range(0, cur_slices)));
            else
                add_request(10'($urandom), 11'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || start || vertex_pair_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [30:0] ra, rb;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset configuration, field extremes and the wrap slice
        add_request(10'd0, 11'd0);
        add_request(10'd0, 11'd4);
        add_request(10'd0, 11'd8);
        add_request(10'd0, 11'd12);
        add_request(10'd0, 11'd15);
        add_request(10'd0, 11'd16);
        add_request(10'd0, 11'd17);
        add_request(10'd1, 11'd3);
        add_request(10'd1023, 11'd0);
        add_request(10'd0, 11'd1024);
        add_request(10'd0, 11'd2047);
        add_request(10'd1023, 11'd2047);
        wait_idle();

        // full-size disk, every ring and slice bit reachable
        set_config(31'd0, 31'h7FFF_FFFF, 11'd1024, 11'd1024);
        add_request(10'd0, 11'd0);
        add_request(10'd1023, 11'd1024);
        add_request(10'd1023, 11'd256);
        add_request(10'd512, 11'd768);
        add_request(10'd1023, 11'd1023);
        wait_idle();

        // outer below inner, then zero outer radius
        set_config(31'h7FFF_FFFF, 31'd0, 11'd3, 11'd1);
        add_request(10'd0, 11'd0);
        add_request(10'd0, 11'd1);
        add_request(10'd0, 11'd3);
        wait_idle();
        set_config(31'd0, 31'd0, 11'd1, 11'd1);
        add_request(10'd0, 11'd0);
        add_request(10'd0, 11'd1);
        wait_idle();

        // bad configurations
        set_config(31'd65536, 31'd131072, 11'd0, 11'd4);
        add_request(10'd0, 11'd0);
        wait_idle();
        set_config(31'd65536, 31'd131072, 11'd1025, 11'd2047);
        add_request(10'd0, 11'd0);
        add_request(10'd3, 11'd5);
        wait_idle();
        set_config(31'd65536, 31'd131072, 11'd8, 11'd0);
        add_request(10'd0, 11'd0);
        wait_idle();

        // random phases; one runs without gaps
        for (int phase = 0; phase < 14; phase++) begin
            ra = 31'($urandom);
            rb = 31'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                ra = 31'($urandom_range(0, 1 << 20));
                rb = ra + 31'($urandom_range(0, 1 << 22));
            end
            if ($urandom_range(0, 4) != 0 && ra > rb) begin
                ra ^= rb; rb ^= ra; ra ^= rb;
            end
            if (phase % 5 == 4)
                set_config(ra, rb, 11'($urandom), 11'($urandom));
            else
                set_config(ra, rb, 11'($urandom_range(1, 1024)),
                           11'($urandom_range(0, 3) == 0 ? $urandom_range(1, 1024)
                                                         : $urandom_range(1, 16)));
            no_gaps = (phase == 6);
            add_random_requests(120);
            wait_idle();
        end
        no_gaps = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && vertex_pair_q.size() == 0)
            $display("disk_vertex_generator_test: done, clean");
        else
            $display("disk_vertex_generator_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dvg_pkg.sv
rtl/core/dvg_cfg.sv
rtl/core/dvg_phase.sv
rtl/core/dvg_qsin.sv
rtl/core/dvg_tex_div.sv
rtl/core/disk_vertex_generator.sv
tb/disk_vertex_generator_test.sv
